// File: rtl/filled_circle_span_generator_top_defines.svh
// ----------------------------------------------------------------------------
// Filled circle span generator assertion macros
// Concurrent check macros; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FILLED_CIRCLE_SPAN_GENERATOR_TOP_DEFINES_SVH
`define FILLED_CIRCLE_SPAN_GENERATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define FCSG_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fcsg check failed");
`define FCSG_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fcsg check failed");
`else
`define FCSG_ASSERT_SAME(name, clk, rst, ante, cons)
`define FCSG_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

// File: rtl/fcsg_pkg.sv
// ----------------------------------------------------------------------------
// Filled circle span generator package
// Shared widths, register indexes, span kinds and controller/datapath types.
// ----------------------------------------------------------------------------
package fcsg_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CFG_W       = 11;
   localparam int IN_COORD_W  = 10;
   localparam int RADIUS_W    = 4;
   localparam int COLOR_W     = 16;
   localparam int COORD_W     = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

   localparam logic [CFG_W-1:0] SCREEN_WIDTH_RESET  = 11'd1024;
   localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RESET = 11'd600;

   typedef enum logic [2:0] {
      KIND_CENTER  = 3'd0,
      KIND_OUTER_P = 3'd1,
      KIND_OUTER_M = 3'd2,
      KIND_INNER_P = 3'd3,
      KIND_INNER_M = 3'd4
   } span_kind_type;

   typedef struct packed {
      logic          load;
      logic          setup;
      logic          emit;
      span_kind_type kind;
      logic          dec_x;
      logic          inc_i;
      logic          flush;
   } ctrl_cmd_type;

   typedef struct packed {
      logic zero_radius;
      logic hit;
      logic outer_ok;
      logic i_last;
   } dp_status_type;

   // r*707/1000 + 1
   function automatic logic [RADIUS_W-1:0] imax_lookup(input logic [RADIUS_W-1:0] r);
      logic [RADIUS_W-1:0] v;
      unique case (r)
         4'd0:  v = 4'd1;
         4'd1:  v = 4'd1;
         4'd2:  v = 4'd2;
         4'd3:  v = 4'd3;
         4'd4:  v = 4'd3;
         4'd5:  v = 4'd4;
         4'd6:  v = 4'd5;
         4'd7:  v = 4'd5;
         4'd8:  v = 4'd6;
         4'd9:  v = 4'd7;
         4'd10: v = 4'd8;
         4'd11: v = 4'd8;
         4'd12: v = 4'd9;
         4'd13: v = 4'd10;
         4'd14: v = 4'd10;
         4'd15: v = 4'd11;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/fcsg_ctrl.sv
// ----------------------------------------------------------------------------
// Filled circle span generator controller
// Sequences setup, the center row, the row walk and the final flush.
// ----------------------------------------------------------------------------
module fcsg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  fcsg_pkg::dp_status_type status,
   output logic                   busy,
   output fcsg_pkg::ctrl_cmd_type cmd
);
   import fcsg_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_SETUP  = 9'b000000010,
      ST_CENTER = 9'b000000100,
      ST_TEST   = 9'b000001000,
      ST_OUT_P  = 9'b000010000,
      ST_OUT_M  = 9'b000100000,
      ST_IN_P   = 9'b001000000,
      ST_IN_M   = 9'b010000000,
      ST_FLUSH  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = status.zero_radius ? ST_FLUSH : ST_CENTER;
         end
         ST_CENTER: begin
            cmd.emit = 1'b1;
            cmd.kind = KIND_CENTER;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            priority if (status.hit && status.outer_ok) begin
               state_in = ST_OUT_P;
            end else if (status.hit) begin
               cmd.dec_x = 1'b1;
               state_in  = ST_IN_P;
            end else begin
               state_in = ST_IN_P;
            end
         end
         ST_OUT_P: begin
            cmd.emit = 1'b1;
            cmd.kind = KIND_OUTER_P;
            state_in = ST_OUT_M;
         end
         ST_OUT_M: begin
            cmd.emit  = 1'b1;
            cmd.kind  = KIND_OUTER_M;
            cmd.dec_x = 1'b1;
            state_in  = ST_IN_P;
         end
         ST_IN_P: begin
            cmd.emit = 1'b1;
            cmd.kind = KIND_INNER_P;
            state_in = ST_IN_M;
         end
         ST_IN_M: begin
            cmd.emit  = 1'b1;
            cmd.kind  = KIND_INNER_M;
            cmd.inc_i = 1'b1;
            state_in  = status.i_last ? ST_FLUSH : ST_TEST;
         end
         ST_FLUSH: begin
            cmd.flush = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/fcsg_datapath.sv
// ----------------------------------------------------------------------------
// Filled circle span generator datapath
// Walk registers, span geometry, screen clamp, pending span and result regs.
// ----------------------------------------------------------------------------
module fcsg_datapath #(
   parameter int MAX_RADIUS = 15
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fcsg_pkg::ctrl_cmd_type            cmd,
   output fcsg_pkg::dp_status_type           status,
   input  logic [fcsg_pkg::CFG_W-1:0]        screen_width,
   input  logic [fcsg_pkg::CFG_W-1:0]        screen_height,
   input  logic [fcsg_pkg::IN_COORD_W-1:0]   req_center_x,
   input  logic [fcsg_pkg::IN_COORD_W-1:0]   req_center_y,
   input  logic [fcsg_pkg::RADIUS_W-1:0]     req_radius,
   input  logic [fcsg_pkg::COLOR_W-1:0]      req_fill_color,
   output logic                              rsp_valid,
   output logic [fcsg_pkg::COORD_W-1:0]      rsp_span_x_start,
   output logic [fcsg_pkg::COORD_W-1:0]      rsp_span_y,
   output logic [fcsg_pkg::COORD_W-1:0]      rsp_span_x_end,
   output logic [fcsg_pkg::COLOR_W-1:0]      rsp_span_color,
   output logic                              rsp_last_span
);
   import fcsg_pkg::*;

   localparam int RW  = $clog2(MAX_RADIUS + 1);
   localparam int IMW = $clog2((MAX_RADIUS * 707) / 1000 + 2);
   localparam int SQW = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 1);
   localparam logic [RADIUS_W-1:0] RMAX_IN = RADIUS_W'(MAX_RADIUS);
   localparam logic [RW-1:0]       RMAX    = RW'(MAX_RADIUS);

   logic [IN_COORD_W-1:0] cx_ff, cy_ff;
   logic [RW-1:0]         r_ff, x_ff;
   logic [COLOR_W-1:0]    color_ff;
   logic [IMW-1:0]        imax_ff, i_ff;
   logic [SQW-1:0]        sqmax_ff;

   logic [SQW-1:0]        dist_sq;

   logic [COORD_W-1:0]    x0, y0, xs_raw, y_raw, len, xs_clamp, y_clamp, w16, h16;
   logic [COORD_W:0]      end_raw;
   logic                  span_ok;

   logic                  pend_valid_ff, pend_valid_in;
   logic [COORD_W-1:0]    pend_xs_ff, pend_y_ff, pend_xe_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]    rsp_xs_ff, rsp_y_ff, rsp_xe_ff;
   logic [COLOR_W-1:0]    rsp_color_ff;
   logic                  rsp_last_ff;

   // walk registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cx_ff    <= req_center_x;
         cy_ff    <= req_center_y;
         color_ff <= req_fill_color;
         r_ff     <= (req_radius > RMAX_IN) ? RMAX : RW'(req_radius);
      end
      if (cmd.setup) begin
         imax_ff  <= IMW'(imax_lookup(RADIUS_W'(r_ff)));
         sqmax_ff <= SQW'(r_ff) * SQW'(r_ff) + SQW'(r_ff >> 1);
         x_ff     <= r_ff;
         i_ff     <= IMW'(1);
      end
      if (cmd.dec_x && (x_ff != '0)) begin
         x_ff <= x_ff - RW'(1);
      end
      if (cmd.inc_i) begin
         i_ff <= i_ff + IMW'(1);
      end
   end

   assign dist_sq = SQW'(i_ff) * SQW'(i_ff) + SQW'(x_ff) * SQW'(x_ff);

   assign status.zero_radius = (r_ff == '0);
   assign status.hit         = (dist_sq > sqmax_ff);
   assign status.outer_ok    = (x_ff > RW'(imax_ff));
   assign status.i_last      = (i_ff == imax_ff);

   // span geometry
   assign x0 = COORD_W'(cx_ff);
   assign y0 = COORD_W'(cy_ff);

   always_comb begin
      unique case (cmd.kind)
         KIND_CENTER: begin
            xs_raw = x0 - COORD_W'(r_ff);
            y_raw  = y0;
            len    = COORD_W'(r_ff) << 1;
         end
         KIND_OUTER_P: begin
            xs_raw = x0 - COORD_W'(i_ff) + COORD_W'(1);
            y_raw  = y0 + COORD_W'(x_ff);
            len    = (COORD_W'(i_ff) - COORD_W'(1)) << 1;
         end
         KIND_OUTER_M: begin
            xs_raw = x0 - COORD_W'(i_ff) + COORD_W'(1);
            y_raw  = y0 - COORD_W'(x_ff);
            len    = (COORD_W'(i_ff) - COORD_W'(1)) << 1;
         end
         KIND_INNER_P: begin
            xs_raw = x0 - COORD_W'(x_ff);
            y_raw  = y0 + COORD_W'(i_ff);
            len    = COORD_W'(x_ff) << 1;
         end
         KIND_INNER_M: begin
            xs_raw = x0 - COORD_W'(x_ff);
            y_raw  = y0 - COORD_W'(i_ff);
            len    = COORD_W'(x_ff) << 1;
         end
         default: begin
            xs_raw = '0;
            y_raw  = '0;
            len    = '0;
         end
      endcase
   end

   // screen clamp
   assign w16     = COORD_W'(screen_width);
   assign h16     = COORD_W'(screen_height);
   assign end_raw = {1'b0, xs_raw} + {1'b0, len} - (COORD_W+1)'(1);

   always_comb begin
      xs_clamp = xs_raw;
      y_clamp  = y_raw;
      if (end_raw >= (COORD_W+1)'(screen_width)) begin
         xs_clamp = w16 - len - COORD_W'(1);
      end
      if (y_raw >= h16) begin
         y_clamp = h16 - COORD_W'(1);
      end
   end

   assign span_ok = cmd.emit && (len != '0);

   // hold one span back so the final one can carry the last flag
   assign rsp_valid_in = pend_valid_ff && (span_ok || cmd.flush);

   always_comb begin
      pend_valid_in = pend_valid_ff;
      priority if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end else if (span_ok) begin
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (span_ok) begin
         pend_xs_ff <= xs_clamp;
         pend_y_ff  <= y_clamp;
         pend_xe_ff <= xs_clamp + len - COORD_W'(1);
      end
      if (rsp_valid_in) begin
         rsp_xs_ff    <= pend_xs_ff;
         rsp_y_ff     <= pend_y_ff;
         rsp_xe_ff    <= pend_xe_ff;
         rsp_color_ff <= color_ff;
         rsp_last_ff  <= cmd.flush;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_span_x_start = rsp_xs_ff;
   assign rsp_span_y       = rsp_y_ff;
   assign rsp_span_x_end   = rsp_xe_ff;
   assign rsp_span_color   = rsp_color_ff;
   assign rsp_last_span    = rsp_last_ff;

endmodule

// File: rtl/filled_circle_span_generator_top.sv
// ----------------------------------------------------------------------------
// Filled circle span generator
// Turns one filled-circle command into clamped horizontal spans, at most one per cycle.
// ----------------------------------------------------------------------------
// Usage: issue a circle with start while busy is low. Spans come out on the
// rsp_ ports one per rsp_valid strobe, each valid for one cycle only, since
// the receiver cannot stall: take every strobe. rsp_last_span marks the final
// span of a circle; a radius of zero gives no spans at all. The span state
// machine keeps busy high while it walks the rows, emitting at most one
// span per cycle. The last span is on the rsp_ ports in the first cycle
// with busy low. Write screen_width and screen_height only while idle.
`include "filled_circle_span_generator_top_defines.svh"

module filled_circle_span_generator_top #(
   parameter int MAX_RADIUS = 15
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [fcsg_pkg::IN_COORD_W-1:0]     req_center_x,
   input  logic [fcsg_pkg::IN_COORD_W-1:0]     req_center_y,
   input  logic [fcsg_pkg::RADIUS_W-1:0]       req_radius,
   input  logic [fcsg_pkg::COLOR_W-1:0]        req_fill_color,
   output logic                                rsp_valid,
   output logic [fcsg_pkg::COORD_W-1:0]        rsp_span_x_start,
   output logic [fcsg_pkg::COORD_W-1:0]        rsp_span_y,
   output logic [fcsg_pkg::COORD_W-1:0]        rsp_span_x_end,
   output logic [fcsg_pkg::COLOR_W-1:0]        rsp_span_color,
   output logic                                rsp_last_span,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fcsg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fcsg_pkg::CFG_W-1:0]          csr_wdata
);
   import fcsg_pkg::*;

   logic [CFG_W-1:0] screen_width_ff, screen_height_ff;
   ctrl_cmd_type     cmd;
   dp_status_type    status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_SCREEN_WIDTH) begin
            screen_width_ff <= csr_wdata;
         end
         if (csr_index == REG_SCREEN_HEIGHT) begin
            screen_height_ff <= csr_wdata;
         end
      end
   end

   fcsg_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   fcsg_datapath #(
      .MAX_RADIUS (MAX_RADIUS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .screen_width     (screen_width_ff),
      .screen_height    (screen_height_ff),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_radius       (req_radius),
      .req_fill_color   (req_fill_color),
      .rsp_valid        (rsp_valid),
      .rsp_span_x_start (rsp_span_x_start),
      .rsp_span_y       (rsp_span_y),
      .rsp_span_x_end   (rsp_span_x_end),
      .rsp_span_color   (rsp_span_color),
      .rsp_last_span    (rsp_last_span)
   );

   `FCSG_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `FCSG_ASSERT_SAME(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy))
   `FCSG_ASSERT_SAME(a_more_spans_busy, clock, reset, rsp_valid && !rsp_last_span, busy)
   `FCSG_ASSERT_NEXT(a_last_gap, clock, reset, rsp_valid && rsp_last_span, !rsp_valid)

endmodule
